// ----- src/top_k_selector_assert.svh -----
// assertion macros shared by the top-k selector checker
`ifndef TOP_K_SELECTOR_ASSERT_SVH
`define TOP_K_SELECTOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define TKS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next one
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tks_pkg.sv -----
// shared types and constants of the top-k selector
package tks_pkg;

    localparam int MAX_K_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_TOP_COUNT = 3'd0;
    localparam logic [COUNT_W-1:0] TOP_COUNT_RST = 5'd16;

    // operation applied to every cell in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } tks_op_t;

    // controller states
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } tks_state_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic                      keep;
        logic signed [VALUE_W-1:0] value;
    } tks_link_t;

endpackage

// ----- src/tks_cell.sv -----
// one cell of the sorted insertion chain
module tks_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tks_pkg::tks_op_t                  op,
    input  logic                              enabled,
    input  logic signed [tks_pkg::VALUE_W-1:0] item_value,
    input  tks_pkg::tks_link_t                left_link,
    input  tks_pkg::tks_link_t                right_link,
    output tks_pkg::tks_link_t                link
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [tks_pkg::VALUE_W-1:0] value_reg;
    logic signed [tks_pkg::VALUE_W-1:0] value_next;
    logic                               valid_eff;
    logic                               keep;

    // entries at or beyond the active count drop out
    assign valid_eff = valid_reg & enabled;
    assign keep      = valid_eff && (value_reg >= item_value);

    assign link.valid = valid_eff;
    assign link.keep  = keep;
    assign link.value = value_reg;

    // insert: keep, take the new value, or take the left neighbor's; shift: take the right neighbor's; else hold
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (op)
            tks_pkg::OP_INSERT:
            begin
                valid_next = enabled && (valid_eff || left_link.valid);
                if (keep)
                begin
                    value_next = value_reg;
                end
                else if (left_link.keep)
                begin
                    value_next = item_value;
                end
                else
                begin
                    value_next = left_link.value;
                end
            end
            tks_pkg::OP_SHIFT:
            begin
                valid_next = right_link.valid;
                value_next = right_link.value;
            end
            default:
            begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // held value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- src/tks_ctrl.sv -----
// fill/drain sequencer and output register of the top-k selector
module tks_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,
    output logic                              m_tlast,
    input  tks_pkg::tks_link_t                head_link,
    input  logic                              more_after_head,
    output tks_pkg::tks_op_t                  op
);

    tks_pkg::tks_state_t                state_reg;
    tks_pkg::tks_state_t                state_next;
    logic [tks_pkg::RANK_W-1:0]         rank_reg;
    logic [tks_pkg::RANK_W-1:0]         rank_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [tks_pkg::VALUE_W-1:0] out_value_reg;
    logic [tks_pkg::RANK_W-1:0]         out_rank_reg;
    logic                               out_last_reg;
    logic                               load;

    // output register is free or being emptied this cycle
    assign load = !out_valid_reg || m_tready;

    // next state and cell operation
    always_comb
    begin
        state_next     = state_reg;
        rank_next      = rank_reg;
        op             = tks_pkg::OP_HOLD;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            tks_pkg::ST_FILL:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op = tks_pkg::OP_INSERT;
                    if (s_tlast)
                    begin
                        state_next = tks_pkg::ST_DRAIN;
                    end
                end
            end
            tks_pkg::ST_DRAIN:
            begin
                if (load)
                begin
                    op             = tks_pkg::OP_SHIFT;
                    out_valid_next = 1'b1;
                    rank_next      = rank_reg + 1'b1;
                    if (!more_after_head)
                    begin
                        state_next = tks_pkg::ST_FILL;
                        rank_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = tks_pkg::ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tks_pkg::ST_FILL;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload taken from the head cell
    always_ff @(posedge clk)
    begin
        if (state_reg == tks_pkg::ST_DRAIN && load)
        begin
            out_value_reg <= head_link.value;
            out_rank_reg  <= rank_reg;
            out_last_reg  <= !more_after_head;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_rank_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/top_k_selector.sv -----
// top level of the streaming top-k selector
// Keeps the top_count largest signed 32-bit values of a set and emits them
// largest first when the set ends.
// Input channel s_*: one value per item in s_tdata, s_tlast marks the set's end.
// Output channel m_*: value and rank (0 is largest) in m_tdata, m_tlast on the
// final result of the set.
// APB port: register top_count at byte address 0 (0 acts as 1, above MAX_K
// acts as MAX_K); write it only while the block is idle.
// Throughput: one input item per cycle while a set streams in; every value
// enters a row of MAX_K compare-and-shift cells at the edge that accepts it.
// On the last item the controller turns to drain and loads the head value into
// the output register, then one result per cycle while m_tready is high, as
// the cells shift toward the head. s_tready stays low from the last item until
// the final result is loaded; a stalled receiver holds the drain and the cells.
// Reset empties all cells, clears the output and sets top_count to 16.
module top_k_selector #(
    parameter int MAX_K = tks_pkg::MAX_K_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // slave side: tdata = value[31:0]
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,
    input  logic                       s_tlast,
    // master side: tdata = value_res[31:0], rank[35:32], zero pad [39:36]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata,
    output logic                       m_tlast,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tks_pkg::ADDR_W-1:0] paddr,
    input  logic [tks_pkg::APB_W-1:0]  pwdata,
    output logic [tks_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    localparam int KW    = $clog2(MAX_K + 1);
    localparam int CMP_W = (KW > tks_pkg::COUNT_W) ? KW : tks_pkg::COUNT_W;

    logic [tks_pkg::COUNT_W-1:0]        top_count_reg;
    logic [CMP_W-1:0]                   tc_wide;
    logic [KW-1:0]                      k_eff;
    logic signed [tks_pkg::VALUE_W-1:0] item_value;
    tks_pkg::tks_op_t                   op;
    tks_pkg::tks_link_t                 links [MAX_K+1];
    tks_pkg::tks_link_t                 left_bound;
    logic                               more_after_head;

    // register write and read
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= tks_pkg::TOP_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr[2] == tks_pkg::ADDR_TOP_COUNT[2])
        begin
            top_count_reg <= pwdata[tks_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == tks_pkg::ADDR_TOP_COUNT[2]) ?
                    {{(tks_pkg::APB_W-tks_pkg::COUNT_W){1'b0}}, top_count_reg} : '0;

    // effective count, clamped to 1..MAX_K
    assign tc_wide = CMP_W'(top_count_reg);

    always_comb
    begin
        if (top_count_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (tc_wide > CMP_W'(MAX_K))
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(tc_wide);
        end
    end

    assign item_value = s_tdata;

    // virtual cell ahead of the head that keeps everything
    assign left_bound = '{valid: 1'b1, keep: 1'b1, value: '0};
    // nothing beyond the tail
    assign links[MAX_K] = '{valid: 1'b0, keep: 1'b0, value: '0};

    // row of cells, head is index 0
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            tks_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .enabled    (KW'(i) < k_eff),
                .item_value (item_value),
                .left_link  (left_bound),
                .right_link (links[i+1]),
                .link       (links[i])
            );
        end
        else
        begin : g_body
            tks_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .enabled    (KW'(i) < k_eff),
                .item_value (item_value),
                .left_link  (links[i-1]),
                .right_link (links[i+1]),
                .link       (links[i])
            );
        end
    end

    assign more_after_head = links[1].valid;

    // sequencer and output stage
    tks_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .head_link       (links[0]),
        .more_after_head (more_after_head),
        .op              (op)
    );

endmodule

// ----- src/tks_checker.sv -----
// port-level checks of the top-k selector and their binding
`include "top_k_selector_assert.svh"

module tks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its payload
    `TKS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // input closes right after the last item of a set
    `TKS_ASSERT_NEXT(a_close_on_last, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last item")

    // input stays closed while the drain is unfinished
    `TKS_ASSERT(a_closed_in_drain, !(m_tvalid && !m_tlast) || !s_tready, "input open during drain")

    // drain runs without gaps and ranks count up
    `TKS_ASSERT_NEXT(a_rank_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[35:32] == $past(m_tdata[35:32]) + 4'd1), "rank sequence broken")

endmodule

bind top_k_selector tks_checker u_tks_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- sim/tb_top.sv -----
// testbench for the top-k selector: directed and random value sets checked against a sorted-insert predictor
`timescale 1ns / 100ps

module tb_top;

    localparam int KEEP_MAX  = tks_pkg::MAX_K_DEF;
    localparam int SETTLE    = 8;
    localparam int WD_LIMIT  = 1000;
    localparam int RUN_LIMIT = 200000;
    localparam int RAND_GOAL = 350;

    typedef struct {
        logic signed [tks_pkg::VALUE_W-1:0] value;
        logic                               last;
    } set_item_t;

    typedef struct {
        logic signed [tks_pkg::VALUE_W-1:0] value;
        logic [tks_pkg::RANK_W-1:0]         rank;
        logic                               last;
    } ranked_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata = '0;
    logic                         s_tlast = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [39:0]                  m_tdata;
    logic                         m_tlast;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [tks_pkg::ADDR_W-1:0]   paddr = '0;
    logic [tks_pkg::APB_W-1:0]    pwdata = '0;
    logic [tks_pkg::APB_W-1:0]    prdata;
    logic                         pready;

    // pending items, predictor state and expected results
    set_item_t                          item_q[$];
    ranked_t                            ranked_out_q[$];
    logic signed [tks_pkg::VALUE_W-1:0] sorted_kept[KEEP_MAX];
    int unsigned                        held_n = 0;
    logic [tks_pkg::COUNT_W-1:0]        top_count_r = tks_pkg::TOP_COUNT_RST;

    int err_count = 0;
    int items_in = 0;
    int sets_in = 0;
    int results_seen = 0;
    int settings_used = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    int run_cycles = 0;
    int unsigned rx_cyc = 0;

    top_k_selector uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // value[31:0]
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // value_res[31:0], rank[35:32], zero pad [39:36]
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // take one value into the kept list; on the set's end queue the ranked results
    task automatic keep_largest(input logic signed [tks_pkg::VALUE_W-1:0] v, input logic lst);
        int unsigned k;
        int unsigned pos;
        bit          skip;
        ranked_t     r;
        k = (top_count_r == 0) ? 1 : ((top_count_r > KEEP_MAX) ? KEEP_MAX : top_count_r);
        skip = 1'b0;
        pos = 0;
        if (held_n > k)
            held_n = k;
        if (held_n < k)
        begin
            pos = held_n;
            held_n++;
        end
        else if (v > sorted_kept[held_n - 1])
            pos = held_n - 1;
        else
            skip = 1'b1;
        if (!skip)
        begin
            while (pos > 0 && sorted_kept[pos - 1] < v)
            begin
                sorted_kept[pos] = sorted_kept[pos - 1];
                pos--;
            end
            sorted_kept[pos] = v;
        end
        if (lst)
        begin
            for (int i = 0; i < held_n; i++)
            begin
                r.value = sorted_kept[i];
                r.rank  = i[tks_pkg::RANK_W-1:0];
                r.last  = (i + 1 == held_n);
                ranked_out_q.insert(ranked_out_q.size(), r);
            end
            held_n = 0;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                keep_largest(item_q[0].value, item_q[0].last);
                if (item_q[0].last)
                    sets_in++;
                item_q.delete(0);
                items_in++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the offered item
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (item_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= item_q[0].value;
                s_tlast  <= item_q[0].last;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern steps through always ready, random and sparse ready modes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (ranked_out_q.size() == 0)
                    report_mismatch($sformatf("unexpected result value %0d rank %0d",
                                    $signed(m_tdata[31:0]), m_tdata[35:32]));
                else
                begin
                    if (m_tdata[31:0] !== ranked_out_q[0].value)
                        report_mismatch($sformatf("value %0d, want %0d (rank %0d)",
                                        $signed(m_tdata[31:0]), ranked_out_q[0].value,
                                        ranked_out_q[0].rank));
                    if (m_tdata[35:32] !== ranked_out_q[0].rank)
                        report_mismatch($sformatf("rank %0d, want %0d",
                                        m_tdata[35:32], ranked_out_q[0].rank));
                    if (m_tlast !== ranked_out_q[0].last)
                        report_mismatch($sformatf("tlast %b, want %b at rank %0d",
                                        m_tlast, ranked_out_q[0].last, ranked_out_q[0].rank));
                    ranked_out_q.delete(0);
                end
            end
            rx_cyc++;
            case (rx_cyc[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (rx_cyc[1:0] == 2'd0);
                default: m_tready <= (rx_cyc % 9 == 0);
            endcase
        end
    end

    // watchdog on cycles with no transfer anywhere, plus a cap on the whole run
    always @(posedge clk)
    begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= RUN_LIMIT)
        begin
            $display("[%0t] timeout: run exceeded %0d cycles", $realtime, RUN_LIMIT);
            $display("tb_top failed");
            $finish;
        end
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT)
        begin
            $display("[%0t] timeout: no transfer for %0d cycles", $realtime, WD_LIMIT);
            $display("tb_top failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic apb_write(input logic [tks_pkg::ADDR_W-1:0] addr,
                             input logic [tks_pkg::APB_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [tks_pkg::ADDR_W-1:0] addr,
                            output logic [tks_pkg::APB_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write top_count, mirror it in the predictor and read it back
    task automatic set_top_count(input logic [tks_pkg::COUNT_W-1:0] k);
        logic [tks_pkg::APB_W-1:0] rd;
        apb_write(tks_pkg::ADDR_TOP_COUNT, {{(tks_pkg::APB_W-tks_pkg::COUNT_W){1'b0}}, k});
        top_count_r = k;
        settings_used++;
        apb_read(tks_pkg::ADDR_TOP_COUNT, rd);
        if (rd !== {{(tks_pkg::APB_W-tks_pkg::COUNT_W){1'b0}}, k})
            report_mismatch($sformatf("top_count reads %0d, want %0d", rd, k));
    endtask

    // wait until every item is taken and every result has come, then settle
    task automatic wait_idle();
        while (item_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (ranked_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_item(input logic signed [tks_pkg::VALUE_W-1:0] v, input logic lst);
        set_item_t it;
        it.value = v;
        it.last  = lst;
        item_q.insert(item_q.size(), it);
    endtask

    function automatic logic signed [tks_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: pick_value = $urandom;
            2:    pick_value = $signed($urandom_range(0, 16)) - 8;
            3:    pick_value = $urandom_range(0, 1) ? 32'sh7FFF_FFF0 + $urandom_range(0, 15)
                                                    : 32'sh8000_0000 + $urandom_range(0, 15);
            4:    pick_value = 32'sd1000 + $urandom_range(0, 200);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: pick_value = 32'sh8000_0000;
                    1: pick_value = 32'sh7FFF_FFFF;
                    2: pick_value = 0;
                    default: pick_value = -1;
                endcase
            end
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [tks_pkg::APB_W-1:0]   rd;
        logic [tks_pkg::COUNT_W-1:0] k_sel;
        logic [tks_pkg::COUNT_W-1:0] k_list[7];
        int unsigned                 k_eff;
        int                          rand_items;
        int                          n_sets;
        int                          len;
        int                          phase;
        bit                          open_set;

        k_list = '{5'd31, 5'd16, 5'd17, 5'd1, 5'd0, 5'd3, 5'd8};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the register
        apb_read(tks_pkg::ADDR_TOP_COUNT, rd);
        if (rd !== {{(tks_pkg::APB_W-tks_pkg::COUNT_W){1'b0}}, tks_pkg::TOP_COUNT_RST})
            report_mismatch($sformatf("top_count after reset reads %0d", rd));

        // field extremes and duplicates with the reset count
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(0, 1'b0);
        push_item(-1, 1'b0);
        push_item(1, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b1);
        // set of a single item
        push_item(5, 1'b1);
        wait_idle();

        // zero count acts as one
        set_top_count(5'd0);
        push_item(3, 1'b0);
        push_item(-7, 1'b0);
        push_item(100, 1'b0);
        push_item(100, 1'b1);
        wait_idle();

        // equal values do not displace a full list
        set_top_count(5'd2);
        push_item(9, 1'b0);
        push_item(9, 1'b0);
        push_item(9, 1'b1);
        wait_idle();

        // count lowered in the middle of a set
        set_top_count(5'd4);
        push_item(10, 1'b0);
        push_item(20, 1'b0);
        push_item(30, 1'b0);
        push_item(40, 1'b0);
        wait_idle();
        set_top_count(5'd2);
        push_item(5, 1'b1);
        wait_idle();

        // random phases, each under a new count; a set may span phases
        rand_items = 0;
        phase = 0;
        open_set = 1'b0;
        while (rand_items < RAND_GOAL)
        begin
            k_sel = (phase < 7) ? k_list[phase] : 5'($urandom_range(0, 31));
            set_top_count(k_sel);
            k_eff = (k_sel == 0) ? 1 : ((k_sel > KEEP_MAX) ? KEEP_MAX : k_sel);
            n_sets = $urandom_range(1, 4);
            for (int s = 0; s < n_sets; s++)
            begin
                if (s == 0 && k_eff == KEEP_MAX)
                    len = $urandom_range(17, 30);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(20, 40);
                else
                    len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_item(pick_value(), i == len - 1);
                rand_items += len;
            end
            open_set = ($urandom_range(0, 2) == 0);
            if (open_set)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    push_item(pick_value(), 1'b0);
                rand_items += len;
            end
            wait_idle();
            phase++;
        end
        if (open_set)
        begin
            push_item(pick_value(), 1'b1);
            wait_idle();
        end

        // drain and look for missing results
        repeat (20) @(posedge clk);
        if (ranked_out_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", ranked_out_q.size()));

        $display("run covered %0d values in %0d sets under %0d top_count settings",
                 items_in, sets_in, settings_used + 1);
        $display("%0d ranked results compared, %0d mismatches", results_seen, err_count);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
